// ----- sv/tal_pkg.sv -----
// shared types and constants for the tree ancestor and lca engine
package tal_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int K_W     = 11;
  localparam int DIST_W  = 11;
  localparam int LEVELS  = 10;
  localparam int LVL_W   = 4;
  localparam int JADDR_W = NODE_W + LVL_W;
  localparam int DEPTH_MAX = (1 << DEPTH_W) - 1;

  typedef enum logic [2:0] {
    CMD_ATTACH = 3'd0,
    CMD_KANC   = 3'd1,
    CMD_LCA    = 3'd2,
    CMD_DIST   = 3'd3,
    CMD_KPATH  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [K_W-1:0]    step_k;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] result_node;
    logic [DIST_W-1:0] result_distance;
  } out_item_t;

endpackage

// ----- sv/tree_ancestor_lca_engine.sv -----
// Binary-lifting ancestor engine: depth and jump tables with a small sequencer.
// One item at a time. Every step is one read of the depth memory or the jump
// memory (one read port each, registered data), and the reads depend on each
// other, so the jump memory port sets the rate. Attach writes the depth and
// the parent jump, then fills each higher jump level from the one below. A
// k-th ancestor query walks the set bits of k, or ends at once with node 0
// when the step runs past the root. LCA, distance and path queries take one
// ancestor walk, paired compares from the top level down and a fetch of the
// parent and its depth (only the depth when the walk already lands on the
// other node), and for the path query a second walk. A pending result is
// raised from idle, and no new word is taken until it is accepted.
// Node 0 always reads as depth 0 with all jumps to 0. No clearing pass.
module tree_ancestor_lca_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tal_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tal_pkg::out_item_t out_item_o
);
  import tal_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DEPA = 15'b000000000000010,
    S_DEPB = 15'b000000000000100,
    S_DISP = 15'b000000000001000,
    S_ATRD = 15'b000000000010000,
    S_ATWR = 15'b000000000100000,
    S_ANC  = 15'b000000001000000,
    S_ANCW = 15'b000000010000000,
    S_LU   = 15'b000000100000000,
    S_LV   = 15'b000001000000000,
    S_LC   = 15'b000010000000000,
    S_LP0  = 15'b000100000000000,
    S_LP1  = 15'b001000000000000,
    S_LDEP = 15'b010000000000000,
    S_LFIN = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]         cmd_q;
  logic [NODE_W-1:0]  a_q, b_q, u_q, u_d, v_q, v_d, tu_q, tu_d;
  logic [NODE_W-1:0]  res_node_q, res_node_d;
  logic [DIST_W-1:0]  res_dist_q, res_dist_d;
  logic [K_W-1:0]     k_q, kk_q, kk_d;
  logic [DEPTH_W-1:0] da_q, da_d, db_q, db_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               ph_q, ph_d;
  logic               out_valid_q, out_valid_d;
  logic               out_pend_q, out_pend_d;

  // memories
  logic [DEPTH_W-1:0] dep_mem [1 << NODE_W];
  logic [NODE_W-1:0]  jmp_mem [1 << JADDR_W];
  logic [NODE_W-1:0]  dep_raddr, jmp_node;
  logic [LVL_W-1:0]   jmp_lvl;
  logic [DEPTH_W-1:0] dep_rd_q, dep_data;
  logic [NODE_W-1:0]  jmp_rd_q, jmp_data;
  logic               dep_zero_q, jmp_zero_q;
  logic               dep_we, jmp_we;
  logic [DEPTH_W-1:0] dep_wdata;
  logic [LVL_W-1:0]   jmp_wlvl;
  logic [NODE_W-1:0]  jmp_wdata;

  logic               accept;
  logic [DEPTH_W:0]   dep_inc;
  logic signed [DEPTH_W+2:0] dist_s, left_s, right_s, tot_s;

  assign accept      = in_valid_i && in_ready_o;
  // hold off input while a result word waits
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q && !out_pend_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o.result_node     = res_node_q;
  assign out_item_o.result_distance = res_dist_q;

  // node 0 reads as all zero
  assign dep_data = dep_zero_q ? '0 : dep_rd_q;
  assign jmp_data = jmp_zero_q ? '0 : jmp_rd_q;

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[a_q] <= dep_wdata;
    end
    if (jmp_we) begin
      jmp_mem[{a_q, jmp_wlvl}] <= jmp_wdata;
    end
    dep_rd_q   <= dep_mem[dep_raddr];
    dep_zero_q <= (dep_raddr == '0);
    jmp_rd_q   <= jmp_mem[{jmp_node, jmp_lvl}];
    jmp_zero_q <= (jmp_node == '0);
  end

  // arithmetic on depths; parent depth arrives on the read port in dispatch
  assign dep_inc = {1'b0, dep_data} + 1'b1;
  always_comb begin
    dist_s  = $signed({3'b000, da_q}) + $signed({3'b000, db_q})
            - $signed({2'b00, dep_data, 1'b0});
    left_s  = $signed({3'b000, da_q}) - $signed({3'b000, dep_data});
    right_s = $signed({3'b000, db_q}) - $signed({3'b000, dep_data});
    tot_s   = left_s + right_s;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    u_d = u_q; v_d = v_q; tu_d = tu_q;
    kk_d = kk_q; lvl_d = lvl_q; ph_d = ph_q;
    da_d = da_q; db_d = db_q;
    res_node_d = res_node_q; res_dist_d = res_dist_q;
    out_pend_d = out_pend_q;
    out_valid_d = out_valid_q;
    dep_raddr = a_q;
    jmp_node = u_q;
    jmp_lvl = lvl_q;
    dep_we = 1'b0;
    dep_wdata = (dep_inc > (DEPTH_W+1)'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX)
                                                     : dep_inc[DEPTH_W-1:0];
    jmp_we = 1'b0;
    jmp_wlvl = lvl_q;
    jmp_wdata = jmp_data;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (out_pend_q && !out_valid_d) begin
          out_valid_d = 1'b1;
          out_pend_d  = 1'b0;
        end
        if (accept) begin
          ph_d = 1'b0;
          res_dist_d = '0;
          res_node_d = '0;
          if (in_item_i.command == CMD_ATTACH) begin
            if (in_item_i.node_a != '0) begin
              state_d = S_DEPA;
            end
          end else if (in_item_i.command == CMD_KANC || in_item_i.command == CMD_LCA ||
                       in_item_i.command == CMD_DIST || in_item_i.command == CMD_KPATH) begin
            state_d = S_DEPA;
          end
        end
      end
      S_DEPA: begin
        dep_raddr = a_q;
        state_d = S_DEPB;
      end
      S_DEPB: begin
        dep_raddr = b_q;
        da_d = dep_data;
        state_d = S_DISP;
      end
      S_DISP: begin
        db_d = dep_data;
        lvl_d = '0;
        if (cmd_q == CMD_ATTACH) begin
          dep_we = 1'b1;
          jmp_we = 1'b1;
          jmp_wlvl = '0;
          jmp_wdata = b_q;
          u_d = b_q;
          lvl_d = LVL_W'(1);
          state_d = (LEVELS == 1) ? S_IDLE : S_ATRD;
        end else if (cmd_q == CMD_KANC) begin
          u_d = a_q;
          kk_d = k_q;
          if (k_q > K_W'(da_q)) begin
            state_d = S_IDLE;
            out_pend_d = 1'b1;
          end else begin
            state_d = S_ANC;
          end
        end else begin
          if (da_q < dep_data) begin
            u_d = b_q; v_d = a_q;
            kk_d = K_W'(dep_data - da_q);
          end else begin
            u_d = a_q; v_d = b_q;
            kk_d = K_W'(da_q - dep_data);
          end
          state_d = S_ANC;
        end
      end
      // attach: fill one jump entry per pass
      S_ATRD: begin
        jmp_node = u_q;
        jmp_lvl = LVL_W'(lvl_q - 1'b1);
        state_d = S_ATWR;
      end
      S_ATWR: begin
        jmp_we = 1'b1;
        jmp_wlvl = lvl_q;
        jmp_wdata = jmp_data;
        u_d = jmp_data;
        lvl_d = LVL_W'(lvl_q + 1'b1);
        state_d = (lvl_q == LVL_W'(LEVELS - 1)) ? S_IDLE : S_ATRD;
      end
      // ancestor walk over the set bits of kk
      S_ANC: begin
        jmp_node = u_q;
        jmp_lvl = lvl_q;
        if (lvl_q == LVL_W'(LEVELS)) begin
          if (cmd_q == CMD_KANC || ph_q) begin
            res_node_d = u_q;
            out_pend_d = 1'b1;
            state_d = S_IDLE;
          end else if (u_q == v_q) begin
            state_d = S_LDEP;
          end else begin
            lvl_d = LVL_W'(LEVELS - 1);
            state_d = S_LU;
          end
        end else if (kk_q[lvl_q]) begin
          state_d = S_ANCW;
        end else begin
          lvl_d = LVL_W'(lvl_q + 1'b1);
        end
      end
      S_ANCW: begin
        u_d = jmp_data;
        lvl_d = LVL_W'(lvl_q + 1'b1);
        state_d = S_ANC;
      end
      // paired climb from the top level down
      S_LU: begin
        jmp_node = u_q;
        state_d = S_LV;
      end
      S_LV: begin
        jmp_node = v_q;
        tu_d = jmp_data;
        state_d = S_LC;
      end
      S_LC: begin
        if (tu_q != jmp_data) begin
          u_d = tu_q;
          v_d = jmp_data;
        end
        if (lvl_q == '0) begin
          state_d = S_LP0;
        end else begin
          lvl_d = LVL_W'(lvl_q - 1'b1);
          state_d = S_LU;
        end
      end
      S_LP0: begin
        jmp_node = u_q;
        jmp_lvl = '0;
        state_d = S_LP1;
      end
      S_LP1: begin
        u_d = jmp_data;
        state_d = S_LDEP;
      end
      S_LDEP: begin
        dep_raddr = u_q;
        state_d = S_LFIN;
      end
      S_LFIN: begin
        state_d = S_IDLE;
        if (cmd_q == CMD_LCA) begin
          res_node_d = u_q;
          out_pend_d = 1'b1;
        end else if (cmd_q == CMD_DIST) begin
          if (dist_s < 0) begin
            res_dist_d = '0;
          end else if (dist_s > $signed((DEPTH_W+3)'((1 << DIST_W) - 1))) begin
            res_dist_d = '1;
          end else begin
            res_dist_d = dist_s[DIST_W-1:0];
          end
          out_pend_d = 1'b1;
        end else begin
          lvl_d = '0;
          ph_d = 1'b1;
          if ($signed({2'b00, k_q}) > tot_s) begin
            res_node_d = '0;
            out_pend_d = 1'b1;
          end else if ($signed({2'b00, k_q}) <= left_s) begin
            u_d = a_q;
            kk_d = k_q;
            state_d = S_ANC;
          end else begin
            u_d = b_q;
            kk_d = K_W'(tot_s - $signed({2'b00, k_q}));
            state_d = S_ANC;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_pend_q  <= 1'b0;
      ph_q        <= 1'b0;
      lvl_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_pend_q  <= out_pend_d;
      ph_q        <= ph_d;
      lvl_q       <= lvl_d;
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_item_i.command;
      a_q   <= in_item_i.node_a;
      b_q   <= in_item_i.node_b;
      k_q   <= in_item_i.step_k;
    end
    u_q <= u_d;
    v_q <= v_d;
    tu_q <= tu_d;
    kk_q <= kk_d;
    da_q <= da_d;
    db_q <= db_d;
    res_node_q <= res_node_d;
    res_dist_q <= res_dist_d;
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_q <= LVL_W'(LEVELS))
    else $error("level counter out of range");
  a_ancw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ANCW |-> $past(state_q) == S_ANC)
    else $error("ancestor step without issue");
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pend_q |-> state_q == S_IDLE)
    else $error("pending result outside idle");
`endif

endmodule
